// ===== design/dcgc_pkg.sv =====
// Shared types, constants and preset table for the dual countdown game clock.
// Used by every module in the design folder; depends on nothing else.
package dcgc_pkg;

    localparam int TIME_W       = 36;
    localparam int PRESET_COUNT = 12;
    localparam int FIELD_W      = 36;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic [25:0] US_PER_MIN = 26'd60_000_000;
    localparam logic [19:0] US_PER_SEC = 20'd1_000_000;

    localparam logic [TIME_W-1:0] T_5S  = TIME_W'(64'd5_000_000);
    localparam logic [TIME_W-1:0] T_6S  = TIME_W'(64'd6_000_000);
    localparam logic [TIME_W-1:0] T_10S = TIME_W'(64'd10_000_000);
    localparam logic [TIME_W-1:0] T_11S = TIME_W'(64'd11_000_000);
    localparam logic [TIME_W-1:0] T_12S = TIME_W'(64'd12_000_000);

    localparam logic [3:0] PRESET_LAST  = 4'(PRESET_COUNT - 1);
    localparam logic [3:0] PRESET_RESET = (2 < PRESET_COUNT) ? 4'd2 : 4'd0;

    localparam logic [7:0] BASE_RESET     = 8'd3;
    localparam logic [3:0] OPTIONS_RESET  = 4'hB;
    localparam logic [7:0] CONTRAST_RESET = 8'd200;

    // option bit positions
    localparam int OPT_STOP      = 0;
    localparam int OPT_BEEP_FLAG = 1;
    localparam int OPT_BEEP_MOVE = 2;
    localparam int OPT_WARN      = 3;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_LEFT  = 3'd1,
        OP_RIGHT = 3'd2,
        OP_TAP   = 3'd3,
        OP_HOLD  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_PAUSE = 3'd2,
        MODE_FLAG  = 3'd3,
        MODE_SETUP = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        SND_NONE  = 3'd0,
        SND_MOVE  = 3'd1,
        SND_WARN  = 3'd2,
        SND_FLAG  = 3'd3,
        SND_SETUP = 3'd4,
        SND_SAVED = 3'd5
    } sound_t;

    typedef enum logic [1:0] {
        WARN_NONE = 2'd0,
        WARN_10S  = 2'd1,
        WARN_5S   = 2'd2
    } warn_t;

    typedef enum logic [3:0] {
        FLD_PRESET    = 4'd0,
        FLD_BASE_L    = 4'd1,
        FLD_INC_L     = 4'd2,
        FLD_BASE_R    = 4'd3,
        FLD_INC_R     = 4'd4,
        FLD_OPT_STOP  = 4'd5,
        FLD_OPT_BFLAG = 4'd6,
        FLD_OPT_BMOVE = 4'd7,
        FLD_OPT_WARN  = 4'd8,
        FLD_CONTRAST  = 4'd9
    } field_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [19:0] elapsed_us;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  run_state;
        logic        active_side;
        logic [35:0] left_remaining_us;
        logic [35:0] right_remaining_us;
        logic        left_flagged;
        logic        right_flagged;
        logic [2:0]  sound_event;
        logic [3:0]  cursor_field;
        logic [3:0]  preset_number;
        logic [7:0]  panel_brightness;
        logic [3:0]  option_bits;
    } status_t;

    typedef struct packed {
        logic [3:0] preset;
        logic [7:0] base_l;
        logic [7:0] base_r;
        logic [5:0] inc_l;
        logic [5:0] inc_r;
        logic [3:0] options;
        logic [7:0] contrast;
    } settings_t;

    function automatic logic [7:0] preset_base(input logic [3:0] p);
        logic [7:0] b;
        unique case (p)
            4'd0:    b = 8'd1;
            4'd1:    b = 8'd2;
            4'd2:    b = 8'd3;
            4'd3:    b = 8'd3;
            4'd4:    b = 8'd5;
            4'd5:    b = 8'd5;
            4'd6:    b = 8'd10;
            4'd7:    b = 8'd10;
            4'd8:    b = 8'd15;
            4'd9:    b = 8'd25;
            4'd10:   b = 8'd30;
            default: b = 8'd60;
        endcase
        return b;
    endfunction

    function automatic logic [5:0] preset_inc(input logic [3:0] p);
        logic [5:0] i;
        unique case (p)
            4'd1:    i = 6'd1;
            4'd3:    i = 6'd2;
            4'd5:    i = 6'd3;
            4'd7:    i = 6'd5;
            4'd8:    i = 6'd10;
            default: i = 6'd0;
        endcase
        return i;
    endfunction

    // low 36 bits of a time value, zero extended when the time is narrower
    function automatic logic [FIELD_W-1:0] to_field(input logic [TIME_W-1:0] t);
        logic [63:0] wide;
        wide = 64'(t);
        return wide[FIELD_W-1:0];
    endfunction

    // base minutes to microseconds, saturated to the time width
    function automatic logic [TIME_W-1:0] start_time(input logic [7:0] minutes);
        logic [63:0] prod;
        prod = 64'(minutes) * 64'(US_PER_MIN);
        return (prod > 64'(TIME_MAX)) ? TIME_MAX : prod[TIME_W-1:0];
    endfunction

endpackage

// ===== design/dcgc_edit.sv =====
// Setup field editor: steps the field under the cursor up or down.
// Depends on dcgc_pkg for the settings type, field codes and preset table.
module dcgc_edit
    import dcgc_pkg::*;
(
    input  logic [3:0] cursor,
    input  logic       up,
    input  settings_t  cur,
    output settings_t  nxt
);

    function automatic logic [9:0] clamp10(input logic signed [9:0] v,
                                           input logic signed [9:0] lo,
                                           input logic signed [9:0] hi);
        logic [9:0] r;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    logic signed [9:0] step;
    logic signed [9:0] step16;
    logic [3:0]        preset_step;
    logic [9:0]        base_l_c;
    logic [9:0]        base_r_c;
    logic [9:0]        inc_l_c;
    logic [9:0]        inc_r_c;
    logic [9:0]        contrast_c;

    assign step   = up ? 10'sd1 : -10'sd1;
    assign step16 = up ? 10'sd16 : -10'sd16;

    always_comb
    begin
        if (up)
            preset_step = (cur.preset == PRESET_LAST) ? 4'd0 : cur.preset + 4'd1;
        else
            preset_step = (cur.preset == 4'd0) ? PRESET_LAST : cur.preset - 4'd1;
    end

    assign base_l_c   = clamp10($signed({2'b00, cur.base_l}) + step, 10'sd1, 10'sd180);
    assign base_r_c   = clamp10($signed({2'b00, cur.base_r}) + step, 10'sd1, 10'sd180);
    assign inc_l_c    = clamp10($signed({4'b0000, cur.inc_l}) + step, 10'sd0, 10'sd60);
    assign inc_r_c    = clamp10($signed({4'b0000, cur.inc_r}) + step, 10'sd0, 10'sd60);
    assign contrast_c = clamp10($signed({2'b00, cur.contrast}) + step16, 10'sd16, 10'sd255);

    always_comb
    begin
        nxt = cur;
        unique case (cursor)
            FLD_PRESET:
            begin
                nxt.preset = preset_step;
                nxt.base_l = preset_base(preset_step);
                nxt.base_r = preset_base(preset_step);
                nxt.inc_l  = preset_inc(preset_step);
                nxt.inc_r  = preset_inc(preset_step);
            end
            FLD_BASE_L:    nxt.base_l   = base_l_c[7:0];
            FLD_INC_L:     nxt.inc_l    = inc_l_c[5:0];
            FLD_BASE_R:    nxt.base_r   = base_r_c[7:0];
            FLD_INC_R:     nxt.inc_r    = inc_r_c[5:0];
            FLD_OPT_STOP:  nxt.options  = cur.options ^ 4'b0001;
            FLD_OPT_BFLAG: nxt.options  = cur.options ^ 4'b0010;
            FLD_OPT_BMOVE: nxt.options  = cur.options ^ 4'b0100;
            FLD_OPT_WARN:  nxt.options  = cur.options ^ 4'b1000;
            FLD_CONTRAST:  nxt.contrast = contrast_c[7:0];
            default:       nxt = cur;
        endcase
    end

endmodule

// ===== design/dcgc_state.sv =====
// Game state registers and the single-pass update for one item.
// Depends on dcgc_pkg and on dcgc_edit for setup field editing.
module dcgc_state
    import dcgc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  cmd_t    cmd,
    output status_t status
);

    mode_t             mode_reg, mode_next;
    logic              side_reg, side_next;
    logic [TIME_W-1:0] rem_l_reg, rem_l_next;
    logic [TIME_W-1:0] rem_r_reg, rem_r_next;
    logic              flag_l_reg, flag_l_next;
    logic              flag_r_reg, flag_r_next;
    warn_t             warn_l_reg, warn_l_next;
    warn_t             warn_r_reg, warn_r_next;
    logic [3:0]        cursor_reg, cursor_next;
    settings_t         set_reg, set_next;
    settings_t         set_edited;
    sound_t            snd;

    logic              press_side;
    logic [TIME_W-1:0] r_act;
    logic [TIME_W-1:0] r_dec;
    logic [TIME_W-1:0] dt;
    logic              flag_act;
    warn_t             warn_act;
    warn_t             lvl;
    warn_t             warn_tick;
    logic [5:0]        inc_act;
    logic [25:0]       add_us;
    logic [TIME_W:0]   r_sum;
    logic [TIME_W-1:0] r_inc;

    dcgc_edit u_edit (
        .cursor (cursor_reg),
        .up     (press_side),
        .cur    (set_reg),
        .nxt    (set_edited)
    );

    assign press_side = (cmd.opcode == OP_RIGHT);
    assign dt         = TIME_W'(cmd.elapsed_us);
    assign r_act      = side_reg ? rem_r_reg : rem_l_reg;
    assign flag_act   = side_reg ? flag_r_reg : flag_l_reg;
    assign warn_act   = side_reg ? warn_r_reg : warn_l_reg;
    assign inc_act    = side_reg ? set_reg.inc_r : set_reg.inc_l;
    assign r_dec      = (dt >= r_act) ? '0 : r_act - dt;

    assign add_us = 26'(inc_act) * 26'(US_PER_SEC);
    assign r_sum  = {1'b0, r_act} + (TIME_W+1)'(add_us);
    assign r_inc  = r_sum[TIME_W] ? TIME_MAX : r_sum[TIME_W-1:0];

    // level of the second window the new time falls in
    always_comb
    begin
        if (r_dec >= T_10S && r_dec < T_11S)
            lvl = WARN_10S;
        else if (r_dec >= T_5S && r_dec < T_6S)
            lvl = WARN_5S;
        else
            lvl = WARN_NONE;
    end

    always_comb
    begin
        warn_tick = warn_act;
        if (lvl != WARN_NONE && warn_act != lvl)
            warn_tick = lvl;
        if (r_dec > T_12S)
            warn_tick = WARN_NONE;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        side_next   = side_reg;
        rem_l_next  = rem_l_reg;
        rem_r_next  = rem_r_reg;
        flag_l_next = flag_l_reg;
        flag_r_next = flag_r_reg;
        warn_l_next = warn_l_reg;
        warn_r_next = warn_r_reg;
        cursor_next = cursor_reg;
        set_next    = set_reg;
        snd         = SND_NONE;

        unique case (cmd.opcode)
            OP_TICK:
            begin
                if (mode_reg == MODE_RUN)
                begin
                    if (side_reg)
                        rem_r_next = r_dec;
                    else
                        rem_l_next = r_dec;
                    if (set_reg.options[OPT_WARN])
                    begin
                        if (lvl != WARN_NONE && warn_act != lvl)
                            snd = SND_WARN;
                        if (side_reg)
                            warn_r_next = warn_tick;
                        else
                            warn_l_next = warn_tick;
                    end
                    if (r_dec == '0)
                    begin
                        if (!flag_act && set_reg.options[OPT_BEEP_FLAG])
                            snd = SND_FLAG;
                        if (side_reg)
                            flag_r_next = 1'b1;
                        else
                            flag_l_next = 1'b1;
                        if (set_reg.options[OPT_STOP])
                            mode_next = MODE_FLAG;
                    end
                end
            end
            OP_LEFT, OP_RIGHT:
            begin
                if (mode_reg == MODE_SETUP)
                    set_next = set_edited;
                else if (mode_reg == MODE_IDLE)
                begin
                    side_next = !press_side;
                    mode_next = MODE_RUN;
                    snd = set_reg.options[OPT_BEEP_MOVE] ? SND_MOVE : SND_NONE;
                end
                else if (mode_reg == MODE_RUN && side_reg == press_side)
                begin
                    // add the increment to the mover and hand over
                    if (side_reg)
                        rem_r_next = r_inc;
                    else
                        rem_l_next = r_inc;
                    side_next = !press_side;
                    snd = set_reg.options[OPT_BEEP_MOVE] ? SND_MOVE : SND_NONE;
                end
            end
            OP_TAP:
            begin
                if (mode_reg == MODE_SETUP)
                    cursor_next = (cursor_reg == FLD_CONTRAST) ? FLD_PRESET
                                                               : cursor_reg + 4'd1;
                else if (mode_reg == MODE_RUN)
                    mode_next = MODE_PAUSE;
                else if (mode_reg == MODE_PAUSE)
                    mode_next = MODE_RUN;
                else
                begin
                    rem_l_next  = start_time(set_reg.base_l);
                    rem_r_next  = start_time(set_reg.base_r);
                    flag_l_next = 1'b0;
                    flag_r_next = 1'b0;
                    mode_next   = MODE_IDLE;
                end
            end
            OP_HOLD:
            begin
                if (mode_reg == MODE_SETUP)
                begin
                    rem_l_next  = start_time(set_reg.base_l);
                    rem_r_next  = start_time(set_reg.base_r);
                    flag_l_next = 1'b0;
                    flag_r_next = 1'b0;
                    mode_next   = MODE_IDLE;
                    snd         = SND_SAVED;
                end
                else if (mode_reg != MODE_RUN)
                begin
                    mode_next   = MODE_SETUP;
                    cursor_next = FLD_PRESET;
                    snd         = SND_SETUP;
                end
            end
            default:
            begin
                snd = SND_NONE;
            end
        endcase
    end

    always_comb
    begin
        status.run_state          = mode_next;
        status.active_side        = side_next;
        status.left_remaining_us  = to_field(rem_l_next);
        status.right_remaining_us = to_field(rem_r_next);
        status.left_flagged       = flag_l_next;
        status.right_flagged      = flag_r_next;
        status.sound_event        = snd;
        status.cursor_field       = cursor_next;
        status.preset_number      = set_next.preset;
        status.panel_brightness   = set_next.contrast;
        status.option_bits        = set_next.options;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            side_reg         <= 1'b0;
            rem_l_reg        <= start_time(BASE_RESET);
            rem_r_reg        <= start_time(BASE_RESET);
            flag_l_reg       <= 1'b0;
            flag_r_reg       <= 1'b0;
            warn_l_reg       <= WARN_NONE;
            warn_r_reg       <= WARN_NONE;
            cursor_reg       <= FLD_PRESET;
            set_reg.preset   <= PRESET_RESET;
            set_reg.base_l   <= BASE_RESET;
            set_reg.base_r   <= BASE_RESET;
            set_reg.inc_l    <= 6'd0;
            set_reg.inc_r    <= 6'd0;
            set_reg.options  <= OPTIONS_RESET;
            set_reg.contrast <= CONTRAST_RESET;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            side_reg   <= side_next;
            rem_l_reg  <= rem_l_next;
            rem_r_reg  <= rem_r_next;
            flag_l_reg <= flag_l_next;
            flag_r_reg <= flag_r_next;
            warn_l_reg <= warn_l_next;
            warn_r_reg <= warn_r_next;
            cursor_reg <= cursor_next;
            set_reg    <= set_next;
        end
    end

endmodule

// ===== design/dual_countdown_game_clock.sv =====
// Top level of the dual countdown game clock: command register, state update
// and status register. Depends on dcgc_pkg and dcgc_state.

// Each command item (tick with elapsed microseconds, left or right press,
// centre tap or hold) yields exactly one status item. An accepted item sits
// in the command register, is applied to the game state in a single
// combinational pass, and its status is captured in the output register at
// the edge that moves the item on, which also raises status_valid. One item
// is taken every cycle while the status side keeps up. A stalled status holds
// the pipeline and the stall propagates straight to cmd_stall. Remaining
// times saturate at zero and at the top of the internal time width; status
// carries their low 36 bits.
module dual_countdown_game_clock
    import dcgc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_stall,
    input  cmd_t    cmd,
    output logic    status_valid,
    input  logic    status_stall,
    output status_t status
);

    logic    cmd_valid_reg, cmd_valid_next;
    cmd_t    cmd_reg;
    logic    status_valid_reg, status_valid_next;
    status_t status_reg;
    status_t status_calc;
    logic    advance;
    logic    accept;

    // move the held item forward when the status slot is free or draining
    assign advance   = cmd_valid_reg && (!status_valid_reg || !status_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    dcgc_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .cmd    (cmd_reg),
        .status (status_calc)
    );

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (accept)
            cmd_valid_next = 1'b1;
        else if (advance)
            cmd_valid_next = 1'b0;

        status_valid_next = status_valid_reg;
        if (advance)
            status_valid_next = 1'b1;
        else if (!status_stall)
            status_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg    <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg    <= cmd_valid_next;
            status_valid_reg <= status_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
        if (advance)
            status_reg <= status_calc;
    end

    assign status_valid = status_valid_reg;
    assign status       = status_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the dual countdown game clock: plans command items
// against its own game-clock predictor and checks every status item in order.
// Depends on dcgc_pkg and the dual_countdown_game_clock top level.
module tb_top;
    import dcgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 1150;
    localparam int          PLAN_CAP     = 6000;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          FIELD_COUNT  = 10;
    localparam int          GAME_CAP     = 500;
    localparam int          SHORT_BASE   = 2;
    localparam logic [19:0] DT_MAX       = 20'd1000000;
    localparam logic [2:0]  OP_SPARE_LO  = 3'(OP_HOLD) + 3'd1;
    localparam logic [63:0] US_SEC       = 64'd1000000;
    localparam logic [63:0] US_MIN       = 64'd60000000;
    localparam logic [63:0] T_TOP        = (64'd1 << TIME_W) - 64'd1;
    localparam logic [TIME_W-1:0] LOW_TIME  = TIME_W'(64'd13000000);
    localparam logic [TIME_W-1:0] LONG_GAME = TIME_W'(64'd900000000);

    localparam logic [7:0] PRESET_MINUTES [16] = '{
        8'd1, 8'd2, 8'd3, 8'd3, 8'd5, 8'd5, 8'd10, 8'd10,
        8'd15, 8'd25, 8'd30, 8'd60, 8'd60, 8'd60, 8'd60, 8'd60
    };
    localparam logic [5:0] PRESET_SECONDS [16] = '{
        6'd0, 6'd1, 6'd0, 6'd2, 6'd0, 6'd3, 6'd0, 6'd5,
        6'd10, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0
    };

    typedef struct packed {
        mode_t                  mode;
        logic                   side;
        logic [1:0][TIME_W-1:0] rem;
        logic [1:0]             flag;
        logic [1:0][7:0]        base;
        logic [1:0][5:0]        inc;
        logic [3:0]             opts;
        logic [7:0]             contrast;
        logic [3:0]             cursor;
        logic [3:0]             preset;
        logic [1:0][1:0]        warned;
    } clock_state_t;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    cmd_valid    = 1'b0;
    logic    cmd_stall;
    cmd_t    cmd          = '0;
    logic    status_valid;
    logic    status_stall = 1'b0;
    status_t status;

    cmd_t         pending_cmds[$];
    status_t      expected_status[$];
    clock_state_t model_state;
    clock_state_t plan_state;
    int           game_items;
    int           mismatches;
    int           burst_left;
    int           idle_gap;
    int           cycles;

    dual_countdown_game_clock DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status       (status)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic int clamp_to(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_game(inout clock_state_t st);
        logic [63:0] t;
        for (int i = 0; i < 2; i++)
        begin
            t = 64'(st.base[i]) * US_MIN;
            st.rem[i] = (t > T_TOP) ? TIME_W'(T_TOP) : TIME_W'(t);
        end
        st.flag = '0;
        st.mode = MODE_IDLE;
    endfunction

    function automatic clock_state_t clock_reset();
        clock_state_t st;
        st          = '0;
        st.mode     = MODE_IDLE;
        st.base[0]  = BASE_RESET;
        st.base[1]  = BASE_RESET;
        st.opts     = OPTIONS_RESET;
        st.contrast = CONTRAST_RESET;
        st.preset   = PRESET_RESET;
        restart_game(st);
        return st;
    endfunction

    function automatic void edit_setting(inout clock_state_t st, input int delta);
        int p;
        case (st.cursor)
            FLD_PRESET:
            begin
                p = (int'(st.preset) + delta + PRESET_COUNT) % PRESET_COUNT;
                st.preset  = 4'(p);
                st.base[0] = PRESET_MINUTES[p & 15];
                st.base[1] = PRESET_MINUTES[p & 15];
                st.inc[0]  = PRESET_SECONDS[p & 15];
                st.inc[1]  = PRESET_SECONDS[p & 15];
            end
            FLD_BASE_L:    st.base[0] = 8'(clamp_to(int'(st.base[0]) + delta, 1, 180));
            FLD_INC_L:     st.inc[0]  = 6'(clamp_to(int'(st.inc[0]) + delta, 0, 60));
            FLD_BASE_R:    st.base[1] = 8'(clamp_to(int'(st.base[1]) + delta, 1, 180));
            FLD_INC_R:     st.inc[1]  = 6'(clamp_to(int'(st.inc[1]) + delta, 0, 60));
            FLD_OPT_STOP:  st.opts[OPT_STOP]      = ~st.opts[OPT_STOP];
            FLD_OPT_BFLAG: st.opts[OPT_BEEP_FLAG] = ~st.opts[OPT_BEEP_FLAG];
            FLD_OPT_BMOVE: st.opts[OPT_BEEP_MOVE] = ~st.opts[OPT_BEEP_MOVE];
            FLD_OPT_WARN:  st.opts[OPT_WARN]      = ~st.opts[OPT_WARN];
            FLD_CONTRAST:
                st.contrast = 8'(clamp_to(int'(st.contrast) + delta * 16, 16, 255));
            default: ;
        endcase
    endfunction

    function automatic sound_t run_down(inout clock_state_t st, input logic [19:0] dt);
        sound_t      snd;
        logic        a;
        logic [63:0] r;
        logic [63:0] secs;
        logic [1:0]  lvl;
        snd = SND_NONE;
        if (st.mode != MODE_RUN) return SND_NONE;
        a = st.side;
        r = 64'(st.rem[a]);
        r = (64'(dt) >= r) ? 64'd0 : r - 64'(dt);
        st.rem[a] = TIME_W'(r);
        if (st.opts[OPT_WARN])
        begin
            secs = r / US_SEC;
            if (secs == 64'd10)     lvl = WARN_10S;
            else if (secs == 64'd5) lvl = WARN_5S;
            else                    lvl = WARN_NONE;
            if (lvl != WARN_NONE && st.warned[a] != lvl)
            begin
                st.warned[a] = lvl;
                snd = SND_WARN;
            end
            // clear the level once the side is well clear of the warnings
            if (r > 12 * US_SEC) st.warned[a] = WARN_NONE;
        end
        if (r == 64'd0)
        begin
            if (!st.flag[a] && st.opts[OPT_BEEP_FLAG]) snd = SND_FLAG;
            st.flag[a] = 1'b1;
            if (st.opts[OPT_STOP]) st.mode = MODE_FLAG;
        end
        return snd;
    endfunction

    function automatic sound_t player_press(inout clock_state_t st, input logic s);
        logic [63:0] add;
        logic [63:0] r;
        sound_t      move_snd;
        if (st.opts[OPT_BEEP_MOVE]) move_snd = SND_MOVE;
        else                        move_snd = SND_NONE;
        if (st.mode == MODE_SETUP)
        begin
            edit_setting(st, s ? 1 : -1);
            return SND_NONE;
        end
        if (st.mode == MODE_IDLE)
        begin
            st.side = ~s;
            st.mode = MODE_RUN;
            return move_snd;
        end
        if (st.mode == MODE_RUN && st.side == s)
        begin
            add = 64'(st.inc[s]) * US_SEC;
            r   = 64'(st.rem[s]);
            st.rem[s] = (add > T_TOP - r) ? TIME_W'(T_TOP) : TIME_W'(r + add);
            st.side = ~s;
            return move_snd;
        end
        return SND_NONE;
    endfunction

    function automatic sound_t clock_step(inout clock_state_t st, input cmd_t c);
        sound_t snd;
        snd = SND_NONE;
        case (c.opcode)
            OP_TICK:  snd = run_down(st, c.elapsed_us);
            OP_LEFT:  snd = player_press(st, 1'b0);
            OP_RIGHT: snd = player_press(st, 1'b1);
            OP_TAP:
            begin
                if (st.mode == MODE_SETUP)
                    st.cursor = 4'((int'(st.cursor) + 1) % FIELD_COUNT);
                else if (st.mode == MODE_RUN)   st.mode = MODE_PAUSE;
                else if (st.mode == MODE_PAUSE) st.mode = MODE_RUN;
                else restart_game(st);
            end
            OP_HOLD:
            begin
                if (st.mode == MODE_SETUP)
                begin
                    restart_game(st);
                    snd = SND_SAVED;
                end
                else if (st.mode != MODE_RUN)
                begin
                    st.mode   = MODE_SETUP;
                    st.cursor = FLD_PRESET;
                    snd       = SND_SETUP;
                end
            end
            default: ;
        endcase
        return snd;
    endfunction

    function automatic status_t status_of(clock_state_t st, sound_t snd);
        status_t s;
        s.run_state          = st.mode;
        s.active_side        = st.side;
        s.left_remaining_us  = 36'(st.rem[0]);
        s.right_remaining_us = 36'(st.rem[1]);
        s.left_flagged       = st.flag[0];
        s.right_flagged      = st.flag[1];
        s.sound_event        = snd;
        s.cursor_field       = st.cursor;
        s.preset_number      = st.preset;
        s.panel_brightness   = st.contrast;
        s.option_bits        = st.opts;
        return s;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [19:0] any_elapsed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return DT_MAX;
        return 20'($urandom_range(0, 1000000));
    endfunction

    function automatic logic [19:0] tick_elapsed(logic [TIME_W-1:0] left_us);
        if ($urandom_range(0, 9) < 2 || left_us < LOW_TIME) return any_elapsed();
        return 20'($urandom_range(600000, 1000000));
    endfunction

    function automatic int burst_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 1;
        if (r < 95) return $urandom_range(2, 20);
        return $urandom_range(20, 70);
    endfunction

    // queue one item and step the planning copy; 1 when the item does anything
    function automatic int offer(logic [2:0] op, logic [19:0] dt);
        cmd_t         c;
        clock_state_t was;
        sound_t       snd;
        c.opcode     = op;
        c.elapsed_us = dt;
        was = plan_state;
        snd = clock_step(plan_state, c);
        pending_cmds.push_back(c);
        if (plan_state.mode == MODE_RUN || plan_state.mode == MODE_PAUSE) game_items++;
        else game_items = 0;
        return (plan_state != was || snd != SND_NONE) ? 1 : 0;
    endfunction

    task automatic plan_step(inout int live);
        int         r;
        int         n;
        int         idx;
        logic       s;
        logic       a;
        logic [3:0] cur;
        logic       long_game;
        r   = $urandom_range(0, 99);
        s   = 1'($urandom_range(0, 1));
        a   = plan_state.side;
        cur = plan_state.cursor;
        long_game = game_items > GAME_CAP ||
                    (plan_state.rem[0] > LONG_GAME && plan_state.rem[1] > LONG_GAME);
        if (r < 3)
        begin
            live += offer(3'($urandom_range(0, 7)), any_elapsed());
            return;
        end
        case (plan_state.mode)
            MODE_IDLE:
            begin
                if (plan_state.base[0] > SHORT_BASE || plan_state.base[1] > SHORT_BASE
                    || r < 25)
                    live += offer(OP_HOLD, any_elapsed());
                else if (r < 90) live += offer(s ? OP_RIGHT : OP_LEFT, any_elapsed());
                else live += offer(OP_TAP, any_elapsed());
            end
            MODE_SETUP:
            begin
                if (r < 33) live += offer(OP_TAP, any_elapsed());
                else if (r < 36 || (r < 45 && plan_state.base[0] <= SHORT_BASE
                                    && plan_state.base[1] <= SHORT_BASE))
                    live += offer(OP_HOLD, any_elapsed());
                else
                begin
                    n = burst_length();
                    if (cur == FLD_BASE_L || cur == FLD_BASE_R)
                    begin
                        idx = (cur == FLD_BASE_R) ? 1 : 0;
                        // pull long bases back down, now and then drive one to the top
                        if (plan_state.base[idx] > SHORT_BASE && $urandom_range(0, 3) != 0)
                        begin
                            s = 1'b0;
                            n = $urandom_range(1, int'(plan_state.base[idx]));
                        end
                        else if ($urandom_range(0, 29) == 0)
                        begin
                            s = 1'b1;
                            n = 180;
                        end
                    end
                    else if (cur == FLD_INC_L || cur == FLD_INC_R)
                    begin
                        idx = (cur == FLD_INC_R) ? 1 : 0;
                        if (plan_state.inc[idx] > 10 && $urandom_range(0, 3) != 0) s = 1'b0;
                    end
                    repeat (n) live += offer(s ? OP_RIGHT : OP_LEFT, any_elapsed());
                end
            end
            MODE_RUN:
            begin
                if (long_game && r < 40) live += offer(OP_TAP, any_elapsed());
                else if (r < 75)
                    live += offer(OP_TICK, tick_elapsed(plan_state.rem[a]));
                else if (r < 88) live += offer(a ? OP_RIGHT : OP_LEFT, any_elapsed());
                else if (r < 91) live += offer(a ? OP_LEFT : OP_RIGHT, any_elapsed());
                else if (r < 95) live += offer(OP_TAP, any_elapsed());
                else live += offer(OP_HOLD, any_elapsed());
            end
            MODE_PAUSE:
            begin
                if (long_game || r >= 80) live += offer(OP_HOLD, any_elapsed());
                else if (r < 45) live += offer(OP_TAP, any_elapsed());
                else if (r < 65) live += offer(OP_TICK, any_elapsed());
                else live += offer(s ? OP_RIGHT : OP_LEFT, any_elapsed());
            end
            default:
            begin
                if (r < 45) live += offer(OP_TAP, any_elapsed());
                else if (r < 70) live += offer(OP_HOLD, any_elapsed());
                else if (r < 85) live += offer(s ? OP_RIGHT : OP_LEFT, any_elapsed());
                else live += offer(OP_TICK, any_elapsed());
            end
        endcase
    endtask

    task automatic plan_directed();
        void'(offer(OP_TICK, DT_MAX));                  // tick while idle
        for (int k = 0; k < 3; k++) void'(offer(OP_SPARE_LO + 3'(k), DT_MAX));
        void'(offer(OP_TAP, '0));                       // restart from idle
        void'(offer(OP_HOLD, '0));                      // enter setup
        repeat (3) void'(offer(OP_LEFT, '0));           // preset wraps below zero
        void'(offer(OP_RIGHT, '0));
        void'(offer(OP_TAP, '0));
        void'(offer(OP_LEFT, DT_MAX));                  // base clamps at one minute
        void'(offer(OP_HOLD, '0));                      // save
        void'(offer(OP_RIGHT, '0));                     // start, left side runs
        void'(offer(OP_HOLD, DT_MAX));                  // hold while running
        void'(offer(OP_RIGHT, '0));                     // opponent's press
        void'(offer(OP_TICK, '0));
        void'(offer(OP_TICK, DT_MAX));
        void'(offer(OP_TAP, '0));                       // pause
        void'(offer(OP_TICK, DT_MAX));
        void'(offer(OP_TAP, '0));                       // resume
        void'(offer(OP_LEFT, '0));                      // move
        void'(offer(OP_TICK, DT_MAX));
        void'(offer(OP_TAP, '0));
        void'(offer(OP_HOLD, '0));                      // setup from pause
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin : drive
        logic    nv;
        cmd_t    nc;
        sound_t  snd;
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            cmd        <= '0;
            burst_left = 0;
            idle_gap   = 0;
        end
        else
        begin
            nv = cmd_valid;
            nc = cmd;
            if (cmd_valid && !cmd_stall)
            begin
                snd = clock_step(model_state, cmd);
                expected_status.push_back(status_of(model_state, snd));
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (idle_gap > 0) idle_gap--;
                else if (pending_cmds.size() > 0)
                begin
                    nc = pending_cmds.pop_front();
                    nv = 1'b1;
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 20);
                        idle_gap   = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3)
                                                                : $urandom_range(4, 15);
                    end
                end
            end
            cmd_valid <= nv;
            cmd       <= nc;
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(posedge clk or negedge rst_n)
    begin : hold_status
        int  hold_off;
        int  phase_left;
        int  style;
        int  run_cycles;
        bit  held;
        if (!rst_n)
        begin
            status_stall <= 1'b0;
            hold_off   = 0;
            phase_left = 0;
            style      = 0;
            run_cycles = 0;
            held       = 1'b0;
        end
        else
        begin
            run_cycles++;
            if (hold_off > 0)
            begin
                hold_off--;
                status_stall <= 1'b1;
            end
            else if (!held && run_cycles >= 600)
            begin
                // long hold-off: let the pipeline fill and back up into cmd_stall
                held     = 1'b1;
                hold_off = 300;
                status_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    style      = $urandom_range(0, 3);
                    phase_left = $urandom_range(16, 200);
                end
                phase_left--;
                case (style)
                    0:       status_stall <= 1'b0;
                    1:       status_stall <= ($urandom_range(0, 3) == 0);
                    2:       status_stall <= ($urandom_range(0, 3) != 0);
                    default: status_stall <= phase_left[2];
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- checker

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("status %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_status
        status_t want;
        if (rst_n && status_valid && !status_stall)
        begin
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("status item with none expected: %h", status);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("run_state", 64'(want.run_state), 64'(status.run_state));
                check_field("active_side", 64'(want.active_side), 64'(status.active_side));
                check_field("left_remaining_us", 64'(want.left_remaining_us),
                            64'(status.left_remaining_us));
                check_field("right_remaining_us", 64'(want.right_remaining_us),
                            64'(status.right_remaining_us));
                check_field("left_flagged", 64'(want.left_flagged),
                            64'(status.left_flagged));
                check_field("right_flagged", 64'(want.right_flagged),
                            64'(status.right_flagged));
                check_field("sound_event", 64'(want.sound_event), 64'(status.sound_event));
                check_field("cursor_field", 64'(want.cursor_field),
                            64'(status.cursor_field));
                check_field("preset_number", 64'(want.preset_number),
                            64'(status.preset_number));
                check_field("panel_brightness", 64'(want.panel_brightness),
                            64'(status.panel_brightness));
                check_field("option_bits", 64'(want.option_bits), 64'(status.option_bits));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("dual_countdown_game_clock: mismatch");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin : run
        int live;
        mismatches  = 0;
        cycles      = 0;
        game_items  = 0;
        live        = 0;
        model_state = clock_reset();
        plan_state  = clock_reset();
        plan_directed();
        while (live < RANDOM_ITEMS && pending_cmds.size() < PLAN_CAP) plan_step(live);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (pending_cmds.size() > 0 || cmd_valid || expected_status.size() > 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("dual_countdown_game_clock: match");
        else
            $display("dual_countdown_game_clock: mismatch");
        $finish;
    end

endmodule
